[hdl/huffman_code_bit_packer_assert.svh]
// ----------------------------------------------------------------------------
// Huffman code bit packer assertion macros
// Shared property wrappers for the checker of the bit packer.
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_CODE_BIT_PACKER_ASSERT_SVH
`define HUFFMAN_CODE_BIT_PACKER_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define HCBP_ASSERT_SAME(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication, disabled while reset is active.
`define HCBP_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

[hdl/hcbp_pkg.sv]
// ----------------------------------------------------------------------------
// Huffman code bit packer package
// Field widths, request codes and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package hcbp_pkg;

  localparam int REQ_W      = 2;
  localparam int SYM_W      = 8;
  localparam int CODE_IN_W  = 32;
  localparam int LEN_IN_W   = 6;
  localparam int BYTE_W     = 8;
  localparam int PCNT_W     = 3;
  localparam int TOTAL_W    = 40;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD   = 2'd0,
    REQ_ENCODE = 2'd1,
    REQ_FLUSH  = 2'd2
  } req_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic mem_wr;   // write the code store entry from the input item
    logic mem_rd;   // read the code store entry for the input symbol
    logic lookup;   // take the read entry into the packing registers
    logic pack;     // perform one packing step
    logic flush;    // emit the flush result and clear the packer
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic entry_empty;  // looked-up code has zero length
    logic pack_emits;   // the next packing step completes a byte
    logic pack_done;    // the next packing step uses up the code
    logic out_free;     // the result register can take a new result
  } dp_stat_t;

endpackage

[hdl/hcbp_in_if.sv]
// ----------------------------------------------------------------------------
// Huffman code bit packer input channel
// Valid/ready channel carrying one request item.
// ----------------------------------------------------------------------------
interface hcbp_in_if
  import hcbp_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [REQ_W-1:0]     req_type;
  logic [SYM_W-1:0]     symbol;
  logic [CODE_IN_W-1:0] code_bits;
  logic [LEN_IN_W-1:0]  code_length;

  modport source (output valid, req_type, symbol, code_bits, code_length, input ready);
  modport sink   (input valid, req_type, symbol, code_bits, code_length, output ready);
endinterface

// ----------------------------------------------------------------------------
// Huffman code bit packer result channel
// Valid/ready channel carrying one packed byte or flush result.
// ----------------------------------------------------------------------------
interface hcbp_out_if
  import hcbp_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [BYTE_W-1:0]  out_byte;
  logic               byte_valid;
  logic [TOTAL_W-1:0] bit_total;
  logic               last;

  modport source (output valid, out_byte, byte_valid, bit_total, last, input ready);
  modport sink   (input valid, out_byte, byte_valid, bit_total, last, output ready);
endinterface

[hdl/hcbp_ctrl.sv]
// ----------------------------------------------------------------------------
// Huffman code bit packer controller
// Sequences load, lookup, packing and flush steps of the datapath.
// ----------------------------------------------------------------------------
module hcbp_ctrl
  import hcbp_pkg::*;
#(
  parameter int SYMBOL_COUNT = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [REQ_W-1:0] in_req_type,
  input  logic [SYM_W-1:0] in_symbol,
  input  dp_stat_t         stat,
  output dp_cmd_t          cmd
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_LOOKUP = 4'b0010,
    S_PACK   = 4'b0100,
    S_FLUSH  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   sym_ok;

  // Symbols beyond the store are ignored by loads and skipped by encodes.
  assign sym_ok = ({1'b0, in_symbol} < (SYM_W + 1)'(SYMBOL_COUNT));

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (req_t'(in_req_type))
            REQ_LOAD: begin
              cmd.mem_wr = sym_ok;
            end
            REQ_ENCODE: begin
              if (sym_ok) begin
                cmd.mem_rd = 1'b1;
                state_nxt  = S_LOOKUP;
              end
            end
            REQ_FLUSH: begin
              state_nxt = S_FLUSH;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_nxt  = stat.entry_empty ? S_IDLE : S_PACK;
      end
      S_PACK: begin
        if (!stat.pack_emits || stat.out_free) begin
          cmd.pack = 1'b1;
          if (stat.pack_done) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_FLUSH: begin
        if (stat.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[hdl/hcbp_datapath.sv]
// ----------------------------------------------------------------------------
// Huffman code bit packer datapath
// Code store, packing shifter, bit counter and result register.
// ----------------------------------------------------------------------------
module hcbp_datapath
  import hcbp_pkg::*;
#(
  parameter int MAX_CODE_LEN = 32,
  parameter int SYMBOL_COUNT = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dp_cmd_t              cmd,
  output dp_stat_t             stat,
  input  logic [SYM_W-1:0]     in_symbol,
  input  logic [CODE_IN_W-1:0] in_code_bits,
  input  logic [LEN_IN_W-1:0]  in_code_length,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [BYTE_W-1:0]    out_byte,
  output logic                 out_byte_valid,
  output logic [TOTAL_W-1:0]   out_bit_total,
  output logic                 out_last
);

  localparam int CODE_W = (MAX_CODE_LEN < CODE_IN_W) ? MAX_CODE_LEN : CODE_IN_W;
  localparam int LEN_W  = $clog2(CODE_W + 1);
  localparam int IDX_W  = $clog2(SYMBOL_COUNT);
  localparam int CMP_W  = (LEN_W > 4) ? LEN_W : 4;
  localparam int WIN_W  = (CODE_W > BYTE_W) ? CODE_W : BYTE_W;
  localparam int ENT_W  = LEN_W + CODE_W;

  // Code store: one entry per symbol, valid bits give the all-zero reset.
  logic [ENT_W-1:0]        mem [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0] vld_r;
  logic [ENT_W-1:0]        rd_r;
  logic                    rd_vld_r;
  logic [IDX_W-1:0]        idx;

  // Load path.
  logic [LEN_IN_W-1:0]  clamp_len;
  logic [CODE_IN_W:0]   one_sh;
  logic [CODE_IN_W-1:0] code_mask;
  logic [ENT_W-1:0]     wr_data;

  // Looked-up entry.
  logic [LEN_W-1:0]  ent_len;
  logic [CODE_W-1:0] ent_bits;

  // Packer state.
  logic [CODE_W-1:0]  rem_bits_r;
  logic [LEN_W-1:0]   rem_len_r;
  logic [BYTE_W-1:0]  pend_r;
  logic [PCNT_W-1:0]  pcnt_r;
  logic [TOTAL_W-1:0] cnt_r;
  logic [TOTAL_W:0]   cnt_sum;

  // Packing step.
  logic [3:0]        avail;
  logic [CMP_W-1:0]  rl_w, av_w, rest;
  logic              emits;
  logic [WIN_W-1:0]  win_sh, win;
  logic [BYTE_W:0]   av_one, rl_one;
  logic [BYTE_W-1:0] full_byte, part_chunk;

  // Result register.
  logic               out_valid_r;
  logic [BYTE_W-1:0]  out_byte_r;
  logic               out_bv_r;
  logic [TOTAL_W-1:0] out_total_r;
  logic               out_last_r;
  logic               out_free;

  assign idx = in_symbol[IDX_W-1:0];

  assign clamp_len = (in_code_length > LEN_IN_W'(CODE_W)) ? LEN_IN_W'(CODE_W) : in_code_length;
  assign one_sh    = (CODE_IN_W + 1)'(1) << clamp_len;
  assign code_mask = one_sh[CODE_IN_W-1:0] - CODE_IN_W'(1);
  assign wr_data   = {clamp_len[LEN_W-1:0], in_code_bits[CODE_W-1:0] & code_mask[CODE_W-1:0]};

  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      mem[idx] <= wr_data;
    end
    if (cmd.mem_rd) begin
      rd_r <= mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (cmd.mem_wr) begin
        vld_r[idx] <= 1'b1;
      end
      if (cmd.mem_rd) begin
        rd_vld_r <= vld_r[idx];
      end
    end
  end

  assign ent_len  = rd_vld_r ? rd_r[ENT_W-1:CODE_W] : '0;
  assign ent_bits = rd_vld_r ? rd_r[CODE_W-1:0] : '0;

  assign avail  = 4'(BYTE_W) - {1'b0, pcnt_r};
  assign rl_w   = CMP_W'(rem_len_r);
  assign av_w   = CMP_W'(avail);
  assign emits  = (rl_w >= av_w);
  assign rest   = rl_w - av_w;
  assign win    = WIN_W'(rem_bits_r);
  assign win_sh = win >> rest;
  assign av_one = (BYTE_W + 1)'(1) << avail;
  assign rl_one = (BYTE_W + 1)'(1) << rl_w[3:0];

  // A full step fills the pending byte with the top bits of the remaining code.
  assign full_byte  = pend_r | (win_sh[BYTE_W-1:0] & (av_one[BYTE_W-1:0] - BYTE_W'(1)));
  // A partial step places all remaining bits just below those already pending.
  assign part_chunk = (win[BYTE_W-1:0] & (rl_one[BYTE_W-1:0] - BYTE_W'(1)))
                      << (avail - rl_w[3:0]);

  assign cnt_sum  = {1'b0, cnt_r} + (TOTAL_W + 1)'(ent_len);
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r    <= '0;
      pcnt_r    <= '0;
      cnt_r     <= '0;
      rem_len_r <= '0;
    end else if (cmd.lookup) begin
      rem_len_r <= ent_len;
      cnt_r     <= cnt_sum[TOTAL_W] ? '1 : cnt_sum[TOTAL_W-1:0];
    end else if (cmd.pack) begin
      if (emits) begin
        pend_r    <= '0;
        pcnt_r    <= '0;
        rem_len_r <= rest[LEN_W-1:0];
      end else begin
        pend_r    <= pend_r | part_chunk;
        pcnt_r    <= pcnt_r + rl_w[PCNT_W-1:0];
        rem_len_r <= '0;
      end
    end else if (cmd.flush) begin
      pend_r <= '0;
      pcnt_r <= '0;
      cnt_r  <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      rem_bits_r <= ent_bits;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((cmd.pack && emits) || cmd.flush) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pack && emits) begin
      out_byte_r  <= full_byte;
      out_bv_r    <= 1'b1;
      out_total_r <= '0;
      out_last_r  <= (rest < CMP_W'(BYTE_W));
    end else if (cmd.flush) begin
      out_byte_r  <= (pcnt_r != '0) ? pend_r : '0;
      out_bv_r    <= (pcnt_r != '0);
      out_total_r <= cnt_r;
      out_last_r  <= 1'b1;
    end
  end

  assign stat.entry_empty = (ent_len == '0);
  assign stat.pack_emits  = emits;
  assign stat.pack_done   = !emits || (rest == '0);
  assign stat.out_free    = out_free;

  assign out_valid      = out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_byte_valid = out_bv_r;
  assign out_bit_total  = out_total_r;
  assign out_last       = out_last_r;

endmodule

[hdl/huffman_code_bit_packer.sv]
// ----------------------------------------------------------------------------
// Huffman code bit packer
// Code store and MSB-first bit packer for the back end of a Huffman encoder.
// ----------------------------------------------------------------------------
// Usage: requests arrive on in_chan, results leave on out_chan; both use a
// valid/ready transfer. A load request writes one symbol's code word and
// length into the code store, with no result. An encode request reads the
// store into a register, takes the entry into the packing registers, then
// packs the code into the pending byte one chunk per cycle, a chunk ending
// at each byte boundary or at the end of the code; a chunk that completes a
// byte waits while the result register is full, and each completed byte is
// a result. A flush waits for a free result register and gives one result
// with the padded partial byte and the total bit count. The block handles
// one request at a time, with a single packing shifter and a registered
// store read.
// Reset clears the code store (per-entry valid bits), the pending byte and
// the bit count at once; requests are taken in the cycle after reset.
// When the receiver stalls, the result stays in the output register and
// byte-completing packing waits for that register; no result is dropped.
// ----------------------------------------------------------------------------
module huffman_code_bit_packer
  import hcbp_pkg::*;
#(
  parameter int MAX_CODE_LEN = 32,
  parameter int SYMBOL_COUNT = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  hcbp_in_if.sink     in_chan,
  hcbp_out_if.source  out_chan
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // The controller owns the handshake on the request side and sequences
  // every datapath step through the command struct.
  hcbp_ctrl #(
    .SYMBOL_COUNT (SYMBOL_COUNT)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_chan.valid),
    .in_ready    (in_chan.ready),
    .in_req_type (in_chan.req_type),
    .in_symbol   (in_chan.symbol),
    .stat        (stat),
    .cmd         (cmd)
  );

  // The datapath holds the store, the packer state and the result register.
  hcbp_datapath #(
    .MAX_CODE_LEN (MAX_CODE_LEN),
    .SYMBOL_COUNT (SYMBOL_COUNT)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_symbol      (in_chan.symbol),
    .in_code_bits   (in_chan.code_bits),
    .in_code_length (in_chan.code_length),
    .out_valid      (out_chan.valid),
    .out_ready      (out_chan.ready),
    .out_byte       (out_chan.out_byte),
    .out_byte_valid (out_chan.byte_valid),
    .out_bit_total  (out_chan.bit_total),
    .out_last       (out_chan.last)
  );

endmodule

[hdl/hcbp_checker.sv]
// ----------------------------------------------------------------------------
// Huffman code bit packer checker
// Port-level assertions on request sequencing and result framing.
// ----------------------------------------------------------------------------
`include "huffman_code_bit_packer_assert.svh"

module hcbp_checker
  import hcbp_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic [REQ_W-1:0]   in_req_type,
  input logic               out_valid,
  input logic               out_ready,
  input logic [BYTE_W-1:0]  out_byte,
  input logic               out_byte_valid,
  input logic [TOTAL_W-1:0] out_bit_total,
  input logic               out_last
);

  // A stalled result keeps its payload.
  `HCBP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(out_bit_total) && $stable(out_last))

  // A load finishes in its own cycle, so the next request can be taken at once.
  `HCBP_ASSERT_NEXT(a_load_one_cycle, clk, rst_n, in_valid && in_ready && (in_req_type == REQ_LOAD), in_ready)

  // A flush always holds off the next request while its result is formed.
  `HCBP_ASSERT_NEXT(a_flush_busy, clk, rst_n, in_valid && in_ready && (in_req_type == REQ_FLUSH), !in_ready)

  // Only flush results carry a count or an empty byte, and they end the item.
  `HCBP_ASSERT_SAME(a_flush_last, clk, rst_n, out_valid && (!out_byte_valid || (out_bit_total != '0)), out_last)

endmodule

bind huffman_code_bit_packer hcbp_checker u_hcbp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_chan.valid),
  .in_ready       (in_chan.ready),
  .in_req_type    (in_chan.req_type),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_byte       (out_chan.out_byte),
  .out_byte_valid (out_chan.byte_valid),
  .out_bit_total  (out_chan.bit_total),
  .out_last       (out_chan.last)
);

[bench/tb.sv]
// ----------------------------------------------------------------------------
// Huffman code bit packer testbench
// Drives load, encode, flush and unused requests into the packer, predicts
// every packed byte and flush result, and checks the result stream in order.
// ----------------------------------------------------------------------------
module tb
  import hcbp_pkg::*;
();

  localparam int          CYCLE_LIMIT  = 200000;
  localparam int          RANDOM_ITEMS = 340;
  localparam int          QUIET_FROM   = 300;
  localparam int          DRAIN_AT     = 150;
  localparam int          SETTLE       = 20;
  localparam int          LEN_CAP      = 32;
  localparam logic [1:0]  REQ_UNUSED   = 2'd3;
  localparam bit [39:0]   COUNT_MAX    = 40'hFF_FFFF_FFFF;

  // Predicts the packer. It holds its own copy of the code store and of the
  // pending byte and bit count, and a queue of the results still due.
  class packer_scoreboard;
    typedef struct {
      bit [7:0]  out_byte;
      bit        byte_valid;
      bit [39:0] bit_total;
      bit        last;
    } packed_result_t;

    bit [5:0]       code_len [256];
    bit [31:0]      code_word [256];
    bit [7:0]       partial;
    bit [2:0]       fill;
    bit [39:0]      bits_sent;
    packed_result_t due_q [$];
    int             errors;

    function new();
      foreach (code_len[i]) begin
        code_len[i]  = '0;
        code_word[i] = '0;
      end
      partial   = '0;
      fill      = '0;
      bits_sent = '0;
      errors    = 0;
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    // Updates the model with one accepted request and queues its results.
    function void note_request(bit [1:0] req, bit [7:0] sym, bit [31:0] word,
                               bit [5:0] len);
      packed_result_t r;
      bit [5:0]       l;
      bit [31:0]      w;
      int             produced;
      produced = 0;
      if (req == REQ_LOAD) begin
        l = (len > LEN_CAP) ? 6'(LEN_CAP) : len;
        w = (l < 32) ? (word & ((32'd1 << l) - 32'd1)) : word;
        code_len[sym]  = l;
        code_word[sym] = w;
      end else if (req == REQ_ENCODE) begin
        l = code_len[sym];
        w = code_word[sym];
        if (l != 0) begin
          for (int i = l; i > 0; i--) begin
            partial[7 - fill] = w[i - 1];
            if (fill == 3'd7) begin
              r.out_byte   = partial;
              r.byte_valid = 1'b1;
              r.bit_total  = '0;
              r.last       = 1'b0;
              due_q.push_back(r);
              produced++;
              partial = '0;
              fill    = '0;
            end else begin
              fill++;
            end
          end
          if (bits_sent > COUNT_MAX - 40'(l))
            bits_sent = COUNT_MAX;
          else
            bits_sent += 40'(l);
          if (produced > 0)
            due_q[due_q.size() - 1].last = 1'b1;
        end
      end else if (req == REQ_FLUSH) begin
        r.out_byte   = (fill != 0) ? partial : 8'd0;
        r.byte_valid = (fill != 0);
        r.bit_total  = bits_sent;
        r.last       = 1'b1;
        due_q.push_back(r);
        partial   = '0;
        fill      = '0;
        bits_sent = '0;
      end
    endfunction

    // Compares one accepted result with the oldest one due.
    function void check_result(bit [7:0] b, bit bv, bit [39:0] tot, bit lst);
      packed_result_t e;
      if (due_q.size() == 0) begin
        $error("unexpected result: out_byte %0h byte_valid %0b bit_total %0d last %0b",
               b, bv, tot, lst);
        errors++;
        return;
      end
      e = due_q.pop_front();
      if (b !== e.out_byte) begin
        $error("out_byte: expected %0h, got %0h", e.out_byte, b);
        errors++;
      end
      if (bv !== e.byte_valid) begin
        $error("byte_valid: expected %0b, got %0b", e.byte_valid, bv);
        errors++;
      end
      if (tot !== e.bit_total) begin
        $error("bit_total: expected %0d, got %0d", e.bit_total, tot);
        errors++;
      end
      if (lst !== e.last) begin
        $error("last: expected %0b, got %0b", e.last, lst);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int   cycle_count = 0;
  bit   quiet = 1'b0;   // set for the last part of the run: no idling at all

  packer_scoreboard sb = new();

  hcbp_in_if  in_if ();
  hcbp_out_if out_if ();

  huffman_code_bit_packer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  // Four time unit clock period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog. A run that has not ended by now has lost a result or hung.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Result monitor. Values are sampled at the edge, before any update made at
  // that edge, so a transfer is seen exactly as the block sees it.
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      sb.check_result(out_if.out_byte, out_if.byte_valid, out_if.bit_total,
                      out_if.last);
  end

  // Receiver. Ready drops for random bursts so that stalls hit every step of
  // the packing, including the middle of a multi-byte code.
  initial begin
    out_if.ready = 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        out_if.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // Presents one request and holds it until the transfer. The scoreboard
  // learns of the request at the edge where it is taken. Valid stays high on
  // return so that a following request can go out back to back.
  task automatic send_item(bit [1:0] req, bit [7:0] sym, bit [31:0] word,
                           bit [5:0] len);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.req_type    <= req;
    in_if.symbol      <= sym;
    in_if.code_bits   <= word;
    in_if.code_length <= len;
    do @(posedge clk); while (!in_if.ready);
    sb.note_request(req, sym, word, len);
  endtask

  // Holds the sender off until every result due has arrived.
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Load lengths lean toward short codes, with some long, overlong and empty.
  function automatic bit [5:0] pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70)      return 6'($urandom_range(1, 12));
    else if (r < 85) return 6'($urandom_range(13, 32));
    else if (r < 95) return 6'd0;
    else             return 6'($urandom_range(33, 63));
  endfunction

  // Most symbols come from a small set so that encodes mostly hit loaded
  // entries; the rest spread over the whole byte range.
  function automatic bit [7:0] pick_symbol();
    if ($urandom_range(0, 4) != 0) return 8'($urandom_range(0, 31));
    else                           return 8'($urandom);
  endfunction

  initial begin
    int       counted;
    int       r;
    bit [1:0] req;

    rst_n             = 1'b0;
    in_if.valid       = 1'b0;
    in_if.req_type    = REQ_LOAD;
    in_if.symbol      = '0;
    in_if.code_bits   = '0;
    in_if.code_length = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. A flush on a fresh packer has nothing pending, and an
    // encode of a symbol that was never loaded produces nothing.
    send_item(REQ_FLUSH,  8'h00, 32'h0000_0000, 6'd0);
    send_item(REQ_ENCODE, 8'h00, 32'h0000_0000, 6'd0);
    // Longest code of all ones, a one-bit code whose upper word bits must be
    // dropped, two overlong lengths that clamp to 32, and an empty code.
    send_item(REQ_LOAD,   8'hFF, 32'hFFFF_FFFF, 6'd32);
    send_item(REQ_LOAD,   8'h00, 32'hAAAA_AAAB, 6'd1);
    send_item(REQ_LOAD,   8'h55, 32'hDEAD_BEEF, 6'd63);
    send_item(REQ_LOAD,   8'hAA, 32'h1234_5678, 6'd40);
    send_item(REQ_LOAD,   8'h01, 32'h5555_5555, 6'd0);
    // Four bytes from one code, a one-bit code, then a code that straddles bytes.
    send_item(REQ_ENCODE, 8'hFF, 32'h0000_0000, 6'd0);
    send_item(REQ_ENCODE, 8'h00, 32'hFFFF_FFFF, 6'd63);
    send_item(REQ_ENCODE, 8'h55, 32'h0000_0000, 6'd0);
    // A symbol with no code is skipped; the unused request type is ignored.
    send_item(REQ_ENCODE, 8'h01, 32'h0000_0000, 6'd0);
    send_item(REQ_UNUSED, 8'h5A, 32'hFFFF_FFFF, 6'd63);
    // Flush with a partial byte, then again with nothing left.
    send_item(REQ_FLUSH,  8'hFF, 32'hFFFF_FFFF, 6'd63);
    send_item(REQ_FLUSH,  8'h00, 32'h0000_0000, 6'd0);
    send_item(REQ_LOAD,   8'h10, 32'h0000_0005, 6'd3);
    send_item(REQ_ENCODE, 8'h10, 32'h0000_0000, 6'd0);
    send_item(REQ_ENCODE, 8'hAA, 32'h0000_0000, 6'd0);
    send_item(REQ_FLUSH,  8'h00, 32'h0000_0000, 6'd0);
    // An exact byte leaves nothing pending but the flush still counts 8 bits.
    send_item(REQ_LOAD,   8'h02, 32'h0000_00FF, 6'd8);
    send_item(REQ_ENCODE, 8'h02, 32'h0000_0000, 6'd0);
    send_item(REQ_FLUSH,  8'h00, 32'h0000_0000, 6'd0);
    // Overwriting an entry with an empty code removes it.
    send_item(REQ_LOAD,   8'hFF, 32'h0000_0000, 6'd0);
    send_item(REQ_ENCODE, 8'hFF, 32'h0000_0000, 6'd0);

    // Random part. The small symbol set is loaded first so that encodes have
    // codes to pack; after that the mix is mostly encodes with some reloads
    // and flushes, and a little noise of the unused request type.
    counted = 0;
    for (int s = 0; s < 32; s++) begin
      send_item(REQ_LOAD, 8'(s), $urandom, pick_length());
      counted++;
    end
    while (counted < RANDOM_ITEMS) begin
      if (counted == DRAIN_AT)
        wait_drained();
      if (counted >= QUIET_FROM)
        quiet = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 15)      req = REQ_LOAD;
      else if (r < 82) req = REQ_ENCODE;
      else if (r < 95) req = REQ_FLUSH;
      else             req = REQ_UNUSED;
      send_item(req, pick_symbol(), $urandom, (req == REQ_LOAD) ? pick_length()
                                                                : 6'($urandom));
      if (req != REQ_UNUSED)
        counted++;
    end

    // Let the last results drain, then keep the clock running so that any
    // result that should not be there shows.
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (sb.errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end
endmodule
